/* rtl/btts_pkg.sv */
// ----------------------------------------------------------------------------
// btts_pkg
// Shared types and constants for the BER-TLV tag search block.
// ----------------------------------------------------------------------------
package btts_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned TagW      = 16;
  localparam int unsigned LenW      = 16;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned OutTdataW = 40;

  // Header byte codes
  localparam logic [4:0] TagMultiByte   = 5'h1f;
  localparam logic [7:0] LenShortMax    = 8'h7f;
  localparam logic [7:0] LenLongOne     = 8'h81;
  localparam logic [7:0] LenLongTwo     = 8'h82;
  localparam int unsigned ConstructedBit = 5;  // bit 0x20 of the first tag byte
  localparam logic [IdxW-1:0] IdxMax    = 8'hff;

  typedef enum logic [7:0] {
    PhTag1  = 8'b0000_0001,
    PhTag2  = 8'b0000_0010,
    PhLen   = 8'b0000_0100,
    PhL81   = 8'b0000_1000,
    PhL82H  = 8'b0001_0000,
    PhL82L  = 8'b0010_0000,
    PhSkip  = 8'b0100_0000,
    PhEmit  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [IdxW-1:0]   byte_index;
    logic [TagW-1:0]   current_tag;
    logic              constructed;
    logic [LenW-1:0]   declared_length;
    logic [LenW-1:0]   bytes_remaining;
    logic              search_ended;
  } scan_state_t;

  typedef struct packed {
    logic [IdxW-1:0]   end_offset;
    logic [LenW-1:0]   value_length;
    logic              truncated;
    logic              format_error;
    logic              found;
    logic              done_res;
    logic              value_valid;
    logic [DataW-1:0]  value_byte;
  } result_t;

endpackage

/* rtl/btts_step.sv */
// ----------------------------------------------------------------------------
// btts_step
// Next-state and result logic for one buffer byte of the tag search.
// ----------------------------------------------------------------------------
module btts_step (
  input  btts_pkg::scan_state_t            state_i,
  input  logic [btts_pkg::DataW-1:0]       data_byte_i,
  input  logic                             last_byte_i,
  input  logic [btts_pkg::TagW-1:0]        target_tag_i,
  output btts_pkg::scan_state_t            state_o,
  output btts_pkg::result_t                result_o
);
  import btts_pkg::*;

  scan_state_t     s;
  result_t         r;
  logic            hdr_done;
  logic            fin;
  logic            fin_found;
  logic            fin_ferr;
  logic            fin_trunc;
  logic [16:0]     fin_end;
  logic [8:0]      idx_p1;

  assign idx_p1 = {1'b0, state_i.byte_index} + 9'd1;

  always_comb begin
    s         = state_i;
    r         = '0;
    hdr_done  = 1'b0;
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_ferr  = 1'b0;
    fin_trunc = 1'b0;
    fin_end   = '0;

    if (!s.search_ended && (target_tag_i == '0)) begin
      fin            = 1'b1;
      s.search_ended = 1'b1;
    end else if (!s.search_ended) begin
      unique case (s.phase)
        PhTag1: begin
          s.current_tag = {8'h00, data_byte_i};
          s.constructed = data_byte_i[ConstructedBit];
          s.phase       = (data_byte_i[4:0] == TagMultiByte) ? PhTag2 : PhLen;
        end
        PhTag2: begin
          s.current_tag = {s.current_tag[7:0], data_byte_i};
          s.phase       = PhLen;
        end
        PhLen: begin
          if ((data_byte_i != 8'h00) && (data_byte_i <= LenShortMax)) begin
            s.declared_length = {8'h00, data_byte_i};
            hdr_done          = 1'b1;
          end else if (data_byte_i == LenLongOne) begin
            s.phase = PhL81;
          end else if (data_byte_i == LenLongTwo) begin
            s.phase = PhL82H;
          end else begin
            fin            = 1'b1;
            fin_ferr       = 1'b1;
            s.search_ended = 1'b1;
          end
        end
        PhL81: begin
          s.declared_length = {8'h00, data_byte_i};
          hdr_done          = 1'b1;
        end
        PhL82H: begin
          s.declared_length = {data_byte_i, 8'h00};
          s.phase           = PhL82L;
        end
        PhL82L: begin
          s.declared_length = {s.declared_length[15:8], data_byte_i};
          hdr_done          = 1'b1;
        end
        PhSkip: begin
          s.bytes_remaining = s.bytes_remaining - 16'd1;
          if (s.bytes_remaining == '0) begin
            s.phase = PhTag1;
          end
        end
        PhEmit: begin
          r.value_byte      = data_byte_i;
          r.value_valid     = 1'b1;
          s.bytes_remaining = s.bytes_remaining - 16'd1;
          if (s.bytes_remaining == '0) begin
            fin            = 1'b1;
            fin_found      = 1'b1;
            fin_end        = {8'h00, idx_p1};
            s.search_ended = 1'b1;
          end
        end
        default: begin
          s.phase = PhTag1;
        end
      endcase

      // Header complete: match, descend, or skip the value
      if (hdr_done) begin
        if (s.current_tag == target_tag_i) begin
          if (s.declared_length == '0) begin
            fin            = 1'b1;
            fin_found      = 1'b1;
            fin_end        = {8'h00, idx_p1};
            s.search_ended = 1'b1;
          end else begin
            s.bytes_remaining = s.declared_length;
            s.phase           = PhEmit;
          end
        end else if (s.constructed || (s.declared_length == '0)) begin
          s.phase = PhTag1;
        end else begin
          s.bytes_remaining = s.declared_length;
          s.phase           = PhSkip;
        end
      end

      // Buffer ends while the search still runs
      if (last_byte_i && !s.search_ended) begin
        fin            = 1'b1;
        s.search_ended = 1'b1;
        if ((s.phase == PhTag1) || (s.phase == PhSkip)) begin
          fin_found = 1'b0;
        end else if (s.phase == PhEmit) begin
          fin_found = 1'b1;
          fin_trunc = 1'b1;
          fin_end   = {8'h00, idx_p1} + {1'b0, s.bytes_remaining};
        end else begin
          fin_ferr = 1'b1;
        end
      end
    end

    if (fin) begin
      r.done_res     = 1'b1;
      r.found        = fin_found;
      r.format_error = fin_ferr;
      r.truncated    = fin_trunc;
      if (fin_found) begin
        r.value_length = s.declared_length;
        r.end_offset   = (fin_end > 17'd255) ? IdxMax : fin_end[IdxW-1:0];
      end
    end

    // Rearm at the end of a buffer, else advance the saturating index
    if (last_byte_i) begin
      s.phase           = PhTag1;
      s.byte_index      = '0;
      s.current_tag     = '0;
      s.constructed     = 1'b0;
      s.declared_length = '0;
      s.bytes_remaining = '0;
      s.search_ended    = 1'b0;
    end else if (s.byte_index != IdxMax) begin
      s.byte_index = s.byte_index + 8'd1;
    end
  end

  assign state_o  = s;
  assign result_o = r;

endmodule

/* rtl/ber_tlv_tag_search.sv */
// ----------------------------------------------------------------------------
// ber_tlv_tag_search
// Streams a BER-TLV buffer byte by byte and reports the value of a chosen tag.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Signals                        Word contents
//  s_axis    in    tvalid/tready/tdata/tlast      tdata[7:0] data_byte,
//                                                 tlast last_byte
//  m_axis    out   tvalid/tready/tdata            one result word per input word
//  cfg       in    cfg_we_i/cfg_wdata_i           target_tag (16 bits)
//
//  Throughput: one word per cycle sustained while the output is not stalled;
//  every input word gives exactly one result word on m_axis.
//  Latency is set by the input register and the result register, with the
//  scan state machine updating between them.
//  Reset clears the scan state, both valid flags and target_tag (to zero,
//  which makes every search end at once without a match).
//  A stalled output holds its word; the input register still drains into the
//  result register as it frees, and s_axis_tready drops only when both are full.
//
module ber_tlv_tag_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [btts_pkg::TagW-1:0]         cfg_wdata_i,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [btts_pkg::DataW-1:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,   // last_byte
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] value_byte, [8] value_valid, [9] done_res, [10] found,
  // [11] format_error, [12] truncated, [28:13] value_length,
  // [36:29] end_offset, [39:37] zero
  output logic [btts_pkg::OutTdataW-1:0]    m_axis_tdata
);
  import btts_pkg::*;

  localparam int unsigned ResW = $bits(result_t);

  logic [TagW-1:0]  target_tag_q;

  logic             in_valid_q;
  logic [DataW-1:0] in_byte_q;
  logic             in_last_q;

  logic             out_valid_q;
  result_t          out_res_q;

  scan_state_t      state_q;
  scan_state_t      state_d;
  result_t          res_d;

  logic             advance;

  // Move the held word forward whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tag_q <= '0;
    end else if (cfg_we_i) begin
      target_tag_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  btts_step u_step (
    .state_i      (state_q),
    .data_byte_i  (in_byte_q),
    .last_byte_i  (in_last_q),
    .target_tag_i (target_tag_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  // Scan state: advance once per word handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= PhTag1;
      state_q.byte_index      <= '0;
      state_q.current_tag     <= '0;
      state_q.constructed     <= 1'b0;
      state_q.declared_length <= '0;
      state_q.bytes_remaining <= '0;
      state_q.search_ended    <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - ResW){1'b0}}, out_res_q};

endmodule

/* rtl/btts_checker.sv */
// ----------------------------------------------------------------------------
// btts_checker
// Port-level checks for the BER-TLV tag search, bound to the top level.
// ----------------------------------------------------------------------------
module btts_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [btts_pkg::OutTdataW-1:0]    m_axis_tdata
);
  import btts_pkg::*;

  result_t res;
  assign res = m_axis_tdata[$bits(result_t)-1:0];

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // With both registers full and the output stalled, input stays closed
  a_in_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready ||
    m_axis_tready || !m_axis_tvalid || $past(m_axis_tready))
    else $error("input opened while pipeline was full");

  // Status flags only come with done, and a truncated value was a match
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.found || res.format_error || res.truncated) |->
    res.done_res && !(res.found && res.format_error) &&
    (!res.truncated || res.found))
    else $error("status flags without done or inconsistent");

  // Length and offset are zero unless the target was found
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.found |->
    (res.value_length == '0) && (res.end_offset == '0))
    else $error("length or offset reported without a match");

endmodule

bind ber_tlv_tag_search btts_checker u_btts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
